// ===== rtl/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types and constants for the breadth-first max-flow block.
// ----------------------------------------------------------------------------
package mfb_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_VERTEX_COUNT  = 2'd0;
  localparam logic [1:0] REG_SOURCE_VERTEX = 2'd1;
  localparam logic [1:0] REG_SINK_VERTEX   = 2'd2;

  // reset values of the configuration registers
  localparam logic [4:0] VERTEX_COUNT_RST  = 5'd16;
  localparam logic [3:0] SOURCE_VERTEX_RST = 4'd0;
  localparam logic [3:0] SINK_VERTEX_RST   = 4'd1;

  // largest flow that the result field carries
  localparam logic [19:0] FLOW_SAT = 20'hFFFFF;

  // edge beat
  typedef struct packed {
    logic        command;
    logic [3:0]  from_vertex;
    logic [3:0]  to_vertex;
    logic [15:0] capacity;
  } item_t;

  // result beat
  typedef struct packed {
    logic [19:0] flow_value;
    logic        error;
  } result_t;

endpackage

// ===== rtl/max_flow_bfs_augmenting.sv =====
// ----------------------------------------------------------------------------
// max_flow_bfs_augmenting
// Edge loader and breadth-first augmenting path max-flow engine.
// ----------------------------------------------------------------------------
// Edge beats are taken one per cycle while busy is low. A beat with command
// set stores its edge and then raises busy for the whole computation: the
// residual copy writes all n*n entries, each search reads the row of every
// queued vertex, and each augmentation walks the path for the bottleneck and
// again to update both directions, all bound by the single port of the
// residual memory (n is the vertex count in use). The result appears for one
// cycle with result_strobe and must be taken then; the receiver cannot stall.
// An error or a source or sink outside the graph goes straight to S_DONE.
// ----------------------------------------------------------------------------
module max_flow_bfs_augmenting #(
  parameter int MAX_VERTICES = 16,
  parameter int CAP_BITS     = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  mfb_pkg::item_t item,
  output logic           result_strobe,
  output mfb_pkg::result_t result,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [4:0]     cfg_data
);

  import mfb_pkg::*;

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int AW    = 2 * VW;
  localparam int DEPTH = 1 << AW;
  localparam int RW    = CAP_BITS + 1;
  localparam int FW    = CAP_BITS + VW + 1;
  localparam int SW    = (FW > 20) ? FW : 20;

  typedef enum logic [3:0] {
    S_IDLE, S_CP_RD, S_CP_WR, S_BFS_INIT, S_POP, S_BFS_RD, S_BFS_CHK,
    S_NK_RD, S_NK_CHK, S_UP_RDF, S_UP_WRF, S_UP_RDB, S_UP_WRB, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [4:0] vertex_count;
  logic [3:0] source_vertex;
  logic [3:0] sink_vertex;

  // engine registers
  logic [CW-1:0]          ci, cj, head, tail, vc;
  logic [VW-1:0]          u, y, xr, src, dst;
  logic [MAX_VERTICES-1:0] visited;
  logic [VW-1:0]          queue [MAX_VERTICES];
  logic [VW-1:0]          parent [MAX_VERTICES];
  logic [RW-1:0]          neck;
  logic [FW-1:0]          flow_total;
  logic                   err;

  // memory ports
  logic          cap_we;
  logic [AW-1:0] cap_waddr, cap_raddr;
  logic [CAP_BITS-1:0] cap_wdata, cap_rdata;
  logic          res_we;
  logic [AW-1:0] res_addr;
  logic [RW-1:0] res_wdata, res_rdata;

  logic [7:0]    n8, vc8, from8, to8, src8, dst8;
  logic [CW-1:0] n;
  logic [VW-1:0] x_link;
  logic          accept;
  logic [SW-1:0] flow_ext;

  // vertex count in use, saturated into 2..MAX_VERTICES
  always_comb begin
    vc8 = {3'b000, vertex_count};
    if (vc8 < 8'd2) begin
      n8 = 8'd2;
    end else if (vc8 > 8'(MAX_VERTICES)) begin
      n8 = 8'(MAX_VERTICES);
    end else begin
      n8 = vc8;
    end
    n     = CW'(n8);
    from8 = {4'b0000, item.from_vertex};
    to8   = {4'b0000, item.to_vertex};
    src8  = {4'b0000, source_vertex};
    dst8  = {4'b0000, sink_vertex};
  end

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign x_link    = parent[y];

  // edge write into the capacity store
  assign cap_we    = accept && (from8 < n8) && (to8 < n8);
  assign cap_waddr = {from8[VW-1:0], to8[VW-1:0]};
  assign cap_wdata = CAP_BITS'(item.capacity);
  assign cap_raddr = {ci[VW-1:0], cj[VW-1:0]};

  // residual port selection
  always_comb begin
    res_we    = 1'b0;
    res_addr  = {u, vc[VW-1:0]};
    res_wdata = res_rdata;
    case (state)
      S_CP_WR: begin
        res_we    = 1'b1;
        res_addr  = {ci[VW-1:0], cj[VW-1:0]};
        res_wdata = RW'(cap_rdata);
      end
      S_NK_RD, S_UP_RDF: res_addr = {x_link, y};
      S_UP_WRF: begin
        res_we    = 1'b1;
        res_addr  = {xr, y};
        res_wdata = res_rdata - neck;
      end
      S_UP_RDB: res_addr = {y, xr};
      S_UP_WRB: begin
        res_we    = 1'b1;
        res_addr  = {y, xr};
        res_wdata = res_rdata + neck;
      end
      default: res_addr = {u, vc[VW-1:0]};
    endcase
  end

  mfb_cap_store #(.DEPTH(DEPTH), .AW(AW), .DW(CAP_BITS)) u_cap (
    .clk     (clk),
    .rst     (rst),
    .clear   (state == S_DONE),
    .wr_en   (cap_we),
    .wr_addr (cap_waddr),
    .wr_data (cap_wdata),
    .rd_addr (cap_raddr),
    .rd_data (cap_rdata)
  );

  mfb_res_store #(.DEPTH(DEPTH), .AW(AW), .DW(RW)) u_res (
    .clk   (clk),
    .we    (res_we),
    .addr  (res_addr),
    .wdata (res_wdata),
    .rdata (res_rdata)
  );

  assign flow_ext = SW'(flow_total);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= VERTEX_COUNT_RST;
      source_vertex <= SOURCE_VERTEX_RST;
      sink_vertex   <= SINK_VERTEX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VERTEX_COUNT:  vertex_count  <= cfg_data;
        REG_SOURCE_VERTEX: source_vertex <= cfg_data[3:0];
        REG_SINK_VERTEX:   sink_vertex   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // sequencer: copy, search, bottleneck walk, path update
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      busy          <= 1'b0;
      result_strobe <= 1'b0;
      result        <= '0;
      flow_total    <= '0;
      visited       <= '0;
      err           <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && item.command) begin
            busy       <= 1'b1;
            flow_total <= '0;
            err        <= 1'b0;
            ci         <= '0;
            cj         <= '0;
            src        <= src8[VW-1:0];
            dst        <= dst8[VW-1:0];
            if (source_vertex == sink_vertex) begin
              err   <= 1'b1;
              state <= S_DONE;
            end else if ((src8 < n8) && (dst8 < n8)) begin
              state <= S_CP_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_CP_RD: state <= S_CP_WR;
        S_CP_WR: begin
          if (cj + 1'b1 == n) begin
            cj <= '0;
            ci <= ci + 1'b1;
            state <= (ci + 1'b1 == n) ? S_BFS_INIT : S_CP_RD;
          end else begin
            cj    <= cj + 1'b1;
            state <= S_CP_RD;
          end
        end
        S_BFS_INIT: begin
          visited    <= MAX_VERTICES'(1) << src;
          queue[0]   <= src;
          head       <= '0;
          tail       <= CW'(1);
          state      <= S_POP;
        end
        S_POP: begin
          if (head != tail) begin
            u     <= queue[head[VW-1:0]];
            head  <= head + 1'b1;
            vc    <= '0;
            state <= S_BFS_RD;
          end else if (visited[dst]) begin
            y     <= dst;
            neck  <= '1;
            state <= S_NK_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_BFS_RD: state <= S_BFS_CHK;
        S_BFS_CHK: begin
          if ((res_rdata != '0) && !visited[vc[VW-1:0]]) begin
            parent[vc[VW-1:0]]  <= u;
            visited[vc[VW-1:0]] <= 1'b1;
            if (tail < CW'(MAX_VERTICES)) begin
              queue[tail[VW-1:0]] <= vc[VW-1:0];
              tail <= tail + 1'b1;
            end
          end
          if (vc + 1'b1 == n) begin
            state <= S_POP;
          end else begin
            vc    <= vc + 1'b1;
            state <= S_BFS_RD;
          end
        end
        S_NK_RD: begin
          xr    <= x_link;
          state <= S_NK_CHK;
        end
        S_NK_CHK: begin
          if (res_rdata < neck) begin
            neck <= res_rdata;
          end
          if (xr == src) begin
            y     <= dst;
            state <= S_UP_RDF;
          end else begin
            y     <= xr;
            state <= S_NK_RD;
          end
        end
        S_UP_RDF: begin
          xr    <= x_link;
          state <= S_UP_WRF;
        end
        S_UP_WRF: state <= S_UP_RDB;
        S_UP_RDB: state <= S_UP_WRB;
        S_UP_WRB: begin
          y <= xr;
          if (xr == src) begin
            flow_total <= flow_total + FW'(neck);
            state      <= S_BFS_INIT;
          end else begin
            state <= S_UP_RDF;
          end
        end
        S_DONE: begin
          result_strobe     <= 1'b1;
          result.error      <= err;
          result.flow_value <= (flow_ext > SW'(FLOW_SAT)) ? FLOW_SAT : flow_ext[19:0];
          busy              <= 1'b0;
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/mfb_cap_store.sv =====
// ----------------------------------------------------------------------------
// mfb_cap_store
// Capacity matrix memory with per-entry valid bits; an entry never written
// since the last clear reads as zero.
// ----------------------------------------------------------------------------
module mfb_cap_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DW-1:0]    rd_q;
  logic             rd_valid;

  // storage array, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // valid bits, cleared at once
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

// ===== rtl/mfb_res_store.sv =====
// ----------------------------------------------------------------------------
// mfb_res_store
// Residual matrix memory, single port, registered read.
// ----------------------------------------------------------------------------
module mfb_res_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // read or write one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
